>>> src/bezier_curve_point_eval_assert.svh
// Assertion macros for the Bezier curve point evaluator.
`ifndef BEZIER_CURVE_POINT_EVAL_ASSERT_SVH
`define BEZIER_CURVE_POINT_EVAL_ASSERT_SVH

// Same-cycle implication on clk, quiet while reset is asserted.
`define BCPE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on clk, quiet while reset is asserted.
`define BCPE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/bcpe_pkg.sv
// Shared types and constants of the Bezier curve point evaluator.
`default_nettype none

package bcpe_pkg;

    localparam int COORD_W  = 32;
    localparam int TAN_W    = 33;
    localparam int IDX_W    = 4;
    localparam int T_IN_W   = 17;
    localparam int CNT_W    = 5;
    localparam int APB_DW   = 32;
    localparam int PADDR_W  = 3;
    localparam int REG_IDX_W = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_POINT_COUNT = '0;
    localparam logic [CNT_W-1:0]     POINT_COUNT_RST = 5'd4;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [TAN_W-1:0]   tan_t;

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } op_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_SINGLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

>>> src/bcpe_if.sv
// Item channels of the Bezier curve point evaluator.
`default_nettype none

interface bcpe_in_if;
    import bcpe_pkg::*;

    logic                valid;
    logic                ready;
    logic                operation;
    logic [IDX_W-1:0]    point_index;
    coord_t              coord_x;
    coord_t              coord_y;
    coord_t              coord_z;
    logic [T_IN_W-1:0]   param_t;

    modport source
    (
        output valid, operation, point_index, coord_x, coord_y, coord_z, param_t,
        input  ready
    );

    modport sink
    (
        input  valid, operation, point_index, coord_x, coord_y, coord_z, param_t,
        output ready
    );
endinterface

interface bcpe_out_if;
    import bcpe_pkg::*;

    logic   valid;
    logic   ready;
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
    tan_t   tan_x;
    tan_t   tan_y;
    tan_t   tan_z;

    modport source
    (
        output valid, pos_x, pos_y, pos_z, tan_x, tan_y, tan_z,
        input  ready
    );

    modport sink
    (
        input  valid, pos_x, pos_y, pos_z, tan_x, tan_y, tan_z,
        output ready
    );
endinterface

`default_nettype wire

>>> src/bcpe_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bcpe_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> src/bezier_curve_point_eval.sv
// Bezier curve point evaluator: de Casteljau reduction over a control point RAM.
// A load item writes the point store when accepted; an evaluate item with n points runs
// n-1 levels, first from the point store, then from the work RAM; one item at a time.
// Each level streams one RAM read per cycle, then drains the 3-stage lerp pipe.
// rst_n clears control state and sets point_count to 4; the point store is not cleared.
`default_nettype none

module bezier_curve_point_eval #(
    parameter int MAX_POINTS  = 16,
    parameter int T_FRAC_BITS = 16
)(
    input  logic                         clk,
    input  logic                         rst_n,
    bcpe_in_if.sink                      req,
    bcpe_out_if.source                   rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bcpe_pkg::PADDR_W-1:0] paddr,
    input  logic [bcpe_pkg::APB_DW-1:0]  pwdata,
    output logic [bcpe_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import bcpe_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int TW = T_FRAC_BITS + 1;
    localparam int PW = TAN_W + TW + 1;
    localparam int DW = 3 * COORD_W;
    localparam logic [TW-1:0] T_ONE = TW'(1) << T_FRAC_BITS;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   point_count_reg;
    logic [CW-1:0]      rd_idx_reg;
    logic [CW-1:0]      m_reg;
    logic               lvl1_reg;
    logic               rv_reg;
    logic [AW-1:0]      ridx_reg;
    logic               s1_v_reg;
    logic [AW-1:0]      s1_idx_reg;
    logic               s2_v_reg;
    logic [AW-1:0]      s2_idx_reg;
    logic               rsp_valid_reg;
    logic [TW-1:0]      t_reg;

    coord_t             prev_reg   [3];
    coord_t             s1_a_reg   [3];
    tan_t               s1_d_reg   [3];
    coord_t             s2_a_reg   [3];
    logic signed [PW-1:0] s2_p_reg [3];
    coord_t             pos_res_reg [3];
    tan_t               tan_res_reg [3];
    coord_t             out_pos_reg [3];
    tan_t               out_tan_reg [3];

    coord_t             cur        [3];
    tan_t               diff       [3];
    coord_t             lerp_val   [3];

    logic               in_ready;
    logic               store_re;
    logic               work_re;
    logic [AW-1:0]      rd_addr;
    logic               start_single;
    logic               start_levels;
    logic               next_level;
    logic               single_cap;
    logic               done_fire;
    logic               store_we;
    logic               cfg_wr;
    logic [CW-1:0]      n_sat;
    logic [TW-1:0]      t_in;
    logic [TW-1:0]      t_sat;
    logic [DW-1:0]      store_q;
    logic [DW-1:0]      work_q;
    logic [DW-1:0]      cur_q;
    logic               last_level;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[PADDR_W-1:2] == REG_POINT_COUNT) ?
                    APB_DW'(point_count_reg) : '0;

    // Operand conditioning
    always_comb
    begin
        if (point_count_reg == '0)
        begin
            n_sat = CW'(1);
        end
        else if (32'(point_count_reg) > MAX_POINTS)
        begin
            n_sat = CW'(MAX_POINTS);
        end
        else
        begin
            n_sat = CW'(point_count_reg);
        end
    end

    assign t_in  = TW'(req.param_t);
    assign t_sat = (t_in > T_ONE) ? T_ONE : t_in;

    assign store_we = (state_reg == ST_IDLE) && req.valid && (req.operation == OP_LOAD) &&
                      (32'(req.point_index) < MAX_POINTS);
    assign last_level = (m_reg == CW'(1));

    // Next state and strobes
    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        store_re     = 1'b0;
        work_re      = 1'b0;
        rd_addr      = rd_idx_reg[AW-1:0];
        start_single = 1'b0;
        start_levels = 1'b0;
        next_level   = 1'b0;
        single_cap   = 1'b0;
        done_fire    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (req.valid && (req.operation == OP_EVAL))
                begin
                    if (n_sat == CW'(1))
                    begin
                        store_re     = 1'b1;
                        rd_addr      = '0;
                        start_single = 1'b1;
                        state_next   = ST_SINGLE;
                    end
                    else
                    begin
                        start_levels = 1'b1;
                        state_next   = ST_ISSUE;
                    end
                end
            end
            ST_SINGLE:
            begin
                single_cap = 1'b1;
                state_next = ST_DONE;
            end
            ST_ISSUE:
            begin
                store_re = lvl1_reg;
                work_re  = !lvl1_reg;
                if (rd_idx_reg == m_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rv_reg && !s1_v_reg && !s2_v_reg)
                begin
                    if (last_level)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        next_level = 1'b1;
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    done_fire  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= POINT_COUNT_RST;
            rd_idx_reg      <= '0;
            m_reg           <= '0;
            lvl1_reg        <= 1'b0;
            rv_reg          <= 1'b0;
            s1_v_reg        <= 1'b0;
            s2_v_reg        <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr && (paddr[PADDR_W-1:2] == REG_POINT_COUNT))
            begin
                point_count_reg <= pwdata[CNT_W-1:0];
            end
            if (start_levels || next_level)
            begin
                rd_idx_reg <= '0;
            end
            else if (state_reg == ST_ISSUE)
            begin
                rd_idx_reg <= CW'(rd_idx_reg + 1'b1);
            end
            if (start_levels)
            begin
                m_reg    <= CW'(n_sat - 1'b1);
                lvl1_reg <= 1'b1;
            end
            else if (next_level)
            begin
                m_reg    <= CW'(m_reg - 1'b1);
                lvl1_reg <= 1'b0;
            end
            rv_reg   <= (state_reg == ST_ISSUE);
            s1_v_reg <= rv_reg && (ridx_reg != '0);
            s2_v_reg <= s1_v_reg;
            if (done_fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Lerp datapath
    assign cur_q = (lvl1_reg || (state_reg == ST_SINGLE)) ? store_q : work_q;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            cur[c]      = cur_q[c*COORD_W +: COORD_W];
            diff[c]     = TAN_W'(cur[c]) - TAN_W'(prev_reg[c]);
            lerp_val[c] = s2_a_reg[c] + s2_p_reg[c][T_FRAC_BITS +: COORD_W];
        end
    end

    always_ff @(posedge clk)
    begin
        ridx_reg   <= rd_idx_reg[AW-1:0];
        s1_idx_reg <= AW'(ridx_reg - 1'b1);
        s2_idx_reg <= s1_idx_reg;
        if (start_levels || start_single)
        begin
            t_reg <= t_sat;
        end
        for (int c = 0; c < 3; c++)
        begin
            if (rv_reg)
            begin
                prev_reg[c] <= cur[c];
                s1_a_reg[c] <= prev_reg[c];
                s1_d_reg[c] <= diff[c];
            end
            s2_a_reg[c] <= s1_a_reg[c];
            s2_p_reg[c] <= s1_d_reg[c] * $signed({1'b0, t_reg});
            if (single_cap)
            begin
                pos_res_reg[c] <= cur[c];
                tan_res_reg[c] <= '0;
            end
            else
            begin
                if (rv_reg && (ridx_reg != '0) && last_level)
                begin
                    tan_res_reg[c] <= diff[c];
                end
                if (s2_v_reg && last_level)
                begin
                    pos_res_reg[c] <= lerp_val[c];
                end
            end
            if (done_fire)
            begin
                out_pos_reg[c] <= pos_res_reg[c];
                out_tan_reg[c] <= tan_res_reg[c];
            end
        end
    end

    bcpe_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_POINTS)
    ) u_store_ram (
        .clk   (clk),
        .we    (store_we),
        .waddr (AW'(req.point_index)),
        .wdata ({req.coord_z, req.coord_y, req.coord_x}),
        .re    (store_re),
        .raddr (rd_addr),
        .rdata (store_q)
    );

    bcpe_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_POINTS)
    ) u_work_ram (
        .clk   (clk),
        .we    (s2_v_reg),
        .waddr (s2_idx_reg),
        .wdata ({lerp_val[2], lerp_val[1], lerp_val[0]}),
        .re    (work_re),
        .raddr (rd_addr),
        .rdata (work_q)
    );

    // Channel outputs
    assign req.ready = in_ready;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.pos_x = out_pos_reg[0];
    assign rsp.pos_y = out_pos_reg[1];
    assign rsp.pos_z = out_pos_reg[2];
    assign rsp.tan_x = out_tan_reg[0];
    assign rsp.tan_y = out_tan_reg[1];
    assign rsp.tan_z = out_tan_reg[2];

`include "bezier_curve_point_eval_assert.svh"

    `BCPE_ASSERT_NOW(a_pipe_in_level, s2_v_reg, (state_reg == ST_ISSUE) || (state_reg == ST_DRAIN), "lerp pipe active outside a level")
    `BCPE_ASSERT_NOW(a_issue_bound, state_reg == ST_ISSUE, rd_idx_reg <= m_reg, "read index past level end")
    `BCPE_ASSERT_NOW(a_write_bound, s2_v_reg, CW'(s2_idx_reg) < m_reg, "work write past level end")
    `BCPE_ASSERT_NOW(a_level_clean, (state_reg == ST_ISSUE) && (rd_idx_reg == '0), !s1_v_reg && !s2_v_reg, "level started with pipe busy")
    `BCPE_ASSERT_NXT(a_done_hold, (state_reg == ST_DONE) && rsp_valid_reg && !rsp.ready, state_reg == ST_DONE, "result dropped while output stalled")

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// Testbench for the Bezier curve evaluator: random and directed items checked against a predictor.
`default_nettype none

module tb_top;
    import bcpe_pkg::*;

    localparam int NPTS          = 16;
    localparam int T_FRAC        = 16;
    localparam int CLK_HALF      = 10;
    localparam int IDLE_PCT      = 34;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES  = 220;
    localparam int STALL_CYCLES  = 400;
    localparam int LIMIT_CYCLES  = 1500000;

    typedef struct {
        coord_t pos_x;
        coord_t pos_y;
        coord_t pos_z;
        tan_t   tan_x;
        tan_t   tan_y;
        tan_t   tan_z;
    } curve_result_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    bcpe_in_if  req_if ();
    bcpe_out_if rsp_if ();

    bezier_curve_point_eval dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_if),
        .rsp     (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    longint          ctrl_pts [NPTS][3];
    logic [CNT_W-1:0] curve_points;
    curve_result_t   pending_points [$];
    curve_result_t   want;
    int              mismatches = 0;
    bit              steady;
    int              stall_seq;
    int              stall_seen = 0;
    int              stall_left = 0;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    function automatic curve_result_t eval_curve(logic [T_IN_W-1:0] t_in);
        longint        work [NPTS][3];
        longint        tng [3];
        longint        t;
        int            n;
        curve_result_t r;
        t = (t_in > (1 << T_FRAC)) ? (longint'(1) << T_FRAC) : longint'(t_in);
        n = curve_points;
        if (n < 1)
            n = 1;
        if (n > NPTS)
            n = NPTS;
        work = ctrl_pts;
        tng = '{0, 0, 0};
        for (int k = 1; k < n; k++)
        begin
            if (k == n - 1)
                for (int c = 0; c < 3; c++)
                    tng[c] = work[1][c] - work[0][c];
            for (int i = 0; i + k < n; i++)
                for (int c = 0; c < 3; c++)
                    work[i][c] = work[i][c] + ((t * (work[i + 1][c] - work[i][c])) >>> T_FRAC);
        end
        r.pos_x = coord_t'(work[0][0]);
        r.pos_y = coord_t'(work[0][1]);
        r.pos_z = coord_t'(work[0][2]);
        r.tan_x = tan_t'(tng[0]);
        r.tan_y = tan_t'(tng[1]);
        r.tan_z = tan_t'(tng[2]);
        return r;
    endfunction

    function automatic coord_t rand_coord();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
        begin
            case ($urandom_range(0, 3))
                0: return 32'sh7fffffff;
                1: return 32'sh80000000;
                2: return 32'sh0;
                default: return -32'sd1;
            endcase
        end
        else if (sel <= 4)
            return coord_t'($urandom);
        else
            return coord_t'(int'($urandom_range(0, 2 * (8 << T_FRAC))) - (8 << T_FRAC));
    endfunction

    function automatic logic [T_IN_W-1:0] rand_t();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return T_IN_W'($urandom_range((1 << T_FRAC) + 1, (1 << T_IN_W) - 1));
        else if (sel == 1)
            return ($urandom_range(0, 1) == 1) ? T_IN_W'(1 << T_FRAC) : '0;
        else
            return T_IN_W'($urandom_range(0, 1 << T_FRAC));
    endfunction

    function automatic int rand_count();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(NPTS + 1, 31);
        else if (sel == 1)
            return 1;
        else if (sel <= 4)
            return $urandom_range(7, NPTS);
        else
            return $urandom_range(2, 6);
    endfunction

    task automatic check_field(string name, longint exp_val, longint act_val);
        if (exp_val != act_val)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_val, act_val);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_points.size() == 0)
            begin
                $display("%0t: unexpected result, actual pos %0d %0d %0d tan %0d %0d %0d",
                         $time, rsp_if.pos_x, rsp_if.pos_y, rsp_if.pos_z,
                         rsp_if.tan_x, rsp_if.tan_y, rsp_if.tan_z);
                mismatches++;
            end
            else
            begin
                want = pending_points.pop_front();
                check_field("pos_x", want.pos_x, rsp_if.pos_x);
                check_field("pos_y", want.pos_y, rsp_if.pos_y);
                check_field("pos_z", want.pos_z, rsp_if.pos_z);
                check_field("tan_x", want.tan_x, rsp_if.tan_x);
                check_field("tan_y", want.tan_y, rsp_if.tan_y);
                check_field("tan_z", want.tan_z, rsp_if.tan_z);
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_seq != stall_seen)
        begin
            stall_seen = stall_seq;
            stall_left = STALL_CYCLES;
        end
        if (stall_left > 0)
        begin
            rsp_if.ready <= 1'b0;
            stall_left--;
        end
        else if (!steady && $urandom_range(0, 99) < IDLE_PCT)
            rsp_if.ready <= 1'b0;
        else
            rsp_if.ready <= 1'b1;
    end

    task automatic send_item(op_t op, logic [IDX_W-1:0] idx, coord_t x, coord_t y, coord_t z,
                             logic [T_IN_W-1:0] t);
        @(negedge clk);
        if (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(negedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.operation   <= op;
        req_if.point_index <= idx;
        req_if.coord_x     <= x;
        req_if.coord_y     <= y;
        req_if.coord_z     <= z;
        req_if.param_t     <= t;
        do
            @(posedge clk);
        while (!req_if.ready);
        if (op == OP_LOAD)
        begin
            ctrl_pts[idx][0] = longint'(x);
            ctrl_pts[idx][1] = longint'(y);
            ctrl_pts[idx][2] = longint'(z);
        end
        else
            pending_points.insert(pending_points.size(), eval_curve(t));
    endtask

    task automatic send_eval(logic [T_IN_W-1:0] t);
        send_item(OP_EVAL, IDX_W'($urandom_range(0, NPTS - 1)), rand_coord(), rand_coord(),
                  rand_coord(), t);
    endtask

    task automatic send_load(logic [IDX_W-1:0] idx);
        send_item(OP_LOAD, idx, rand_coord(), rand_coord(), rand_coord(), rand_t());
    endtask

    // drop valid, wait for every expected result, then let the block go idle
    task automatic settle();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DW-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == REG_POINT_COUNT)
            curve_points = val[CNT_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_curve_phase(int count_val, int items, int eval_pct);
        settle();
        write_reg(REG_POINT_COUNT, APB_DW'(count_val));
        repeat (items)
        begin
            if ($urandom_range(0, 99) < eval_pct)
                send_eval(rand_t());
            else
                send_load(IDX_W'($urandom_range(0, NPTS - 1)));
        end
    endtask

    task automatic test_directed_extremes();
        send_item(OP_LOAD, 4'd0, 32'sh7fffffff, 32'sh80000000, 32'sh0, '0);
        send_item(OP_LOAD, 4'd1, 32'sh80000000, 32'sh7fffffff, -32'sd1, '1);
        send_item(OP_LOAD, 4'd2, 32'sh0, -32'sd1, 32'sh7fffffff, '0);
        send_item(OP_LOAD, 4'd3, -32'sd1, 32'sh80000000, 32'sh00010000, '1);
        for (int i = 4; i < NPTS; i++)
            send_load(IDX_W'(i));
        send_eval('0);
        send_eval(T_IN_W'(1));
        send_eval(T_IN_W'(1 << (T_FRAC - 1)));
        send_eval(T_IN_W'((1 << T_FRAC) - 1));
        send_eval(T_IN_W'(1 << T_FRAC));
        send_eval(T_IN_W'((1 << T_FRAC) + 1));
        send_eval('1);
    endtask

    task automatic test_point_count_range();
        int counts [6];
        counts = '{1, NPTS, 0, 31, NPTS + 1, 2};
        foreach (counts[i])
        begin
            settle();
            write_reg(REG_POINT_COUNT, APB_DW'(counts[i]));
            send_eval(rand_t());
            send_load(IDX_W'($urandom_range(0, NPTS - 1)));
            send_eval('0);
            send_eval(T_IN_W'(1 << T_FRAC));
        end
    endtask

    task automatic test_random_curves();
        repeat (18)
            run_curve_phase(rand_count(), 50, $urandom_range(30, 70));
    endtask

    task automatic test_steady_stream();
        settle();
        steady = 1'b1;
        run_curve_phase(3, 80, 50);
        settle();
        steady = 1'b0;
    endtask

    task automatic test_backpressure();
        settle();
        write_reg(REG_POINT_COUNT, APB_DW'(5));
        stall_seq++;
        repeat (20)
        begin
            if ($urandom_range(0, 99) < 75)
                send_eval(rand_t());
            else
                send_load(IDX_W'($urandom_range(0, NPTS - 1)));
        end
        settle();
    endtask

    initial
    begin
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        req_if.valid       = 1'b0;
        req_if.operation   = OP_LOAD;
        req_if.point_index = '0;
        req_if.coord_x     = '0;
        req_if.coord_y     = '0;
        req_if.coord_z     = '0;
        req_if.param_t     = '0;
        steady             = 1'b0;
        stall_seq          = 0;
        curve_points       = POINT_COUNT_RST;
        foreach (ctrl_pts[i, c])
            ctrl_pts[i][c] = 0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        test_directed_extremes();
        test_point_count_range();
        test_random_curves();
        test_steady_stream();
        test_backpressure();

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial
    begin
        #(2 * CLK_HALF * LIMIT_CYCLES);
        $display("tb_top failed");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+src
src/bcpe_pkg.sv
src/bcpe_if.sv
src/bcpe_ram.sv
src/bezier_curve_point_eval.sv
bench/tb_top.sv
